FILE: src/gwh_pkg.sv
// shared types, codes and constants for the greyscale converter with histograms
package gwh_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int OUT_COUNT_W     = 24;
    localparam int PIX_W           = 8;
    localparam int FINE_BINS       = 256;
    localparam int COARSE_BINS     = 10;
    localparam int COARSE_IDX_W    = $clog2(COARSE_BINS);
    localparam int QUEUE_DEPTH     = 4;

    // weighted sum and reciprocal constants
    localparam int SUM_W      = 15;
    localparam int W_RED      = 21;
    localparam int W_GREEN    = 71;
    localparam int W_BLUE     = 7;
    localparam int AVG_RECIP  = 683;
    localparam int AVG_SHIFT  = 11;
    localparam int LUMA_RECIP = 5243;
    localparam int LUMA_SHIFT = 19;
    localparam int AVG_PROD_W  = 22;
    localparam int LUMA_PROD_W = 28;

    typedef enum logic [1:0] {
        CMD_CONVERT     = 2'd0,
        CMD_READ_FINE   = 2'd1,
        CMD_READ_COARSE = 2'd2,
        CMD_CLEAR       = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        METHOD_AVERAGE     = 2'd0,
        METHOD_LIGHTNESS   = 2'd1,
        METHOD_LUMINOSITY  = 2'd2,
        METHOD_AVERAGE_ALT = 2'd3
    } method_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [PIX_W-1:0]   grey;
        logic [PIX_W-1:0]   bin_index;
    } gwh_entry_t;

    // coarse bin of a grey value: grey * 10 / 256
    function automatic logic [COARSE_IDX_W-1:0] coarse_bin(input logic [PIX_W-1:0] g);
        logic [PIX_W+COARSE_IDX_W-1:0] prod;
        prod = (PIX_W+COARSE_IDX_W)'(g) * (PIX_W+COARSE_IDX_W)'(COARSE_BINS);
        return prod[PIX_W+COARSE_IDX_W-1:PIX_W];
    endfunction

endpackage

FILE: src/gwh_front.sv
// front end: input transfer, config register and two-stage grey computation
module gwh_front
    import gwh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red, green, blue, bin_index
    input  logic [1:0]  s_tuser,   // command
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,  // grey_method
    output logic        push_valid,
    input  logic        push_ready,
    output gwh_entry_t  push_entry
);

    method_t method_reg;

    logic               f1_valid_reg;
    cmd_t               f1_cmd_reg;
    method_t            f1_method_reg;
    logic [SUM_W-1:0]   f1_sum_reg;
    logic [PIX_W-1:0]   f1_idx_reg;

    logic               f2_valid_reg;
    gwh_entry_t         f2_entry_reg;

    logic [PIX_W-1:0]   red, green, blue;
    logic [PIX_W-1:0]   hi, lo;
    logic [SUM_W-1:0]   sum_next;
    logic [PIX_W-1:0]   grey_next;
    logic [AVG_PROD_W-1:0]  avg_prod;
    logic [LUMA_PROD_W-1:0] luma_prod;
    logic               f1_adv;
    logic               f2_adv;

    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];

    assign cfg_ready = 1'b1;

    assign f2_adv   = !f2_valid_reg || push_ready;
    assign f1_adv   = !f1_valid_reg || f2_adv;
    assign s_tready = f1_adv;

    assign push_valid = f2_valid_reg;
    assign push_entry = f2_entry_reg;

    always_comb
    begin
        hi = red;
        lo = red;
        if (green > hi)
        begin
            hi = green;
        end
        if (blue > hi)
        begin
            hi = blue;
        end
        if (green < lo)
        begin
            lo = green;
        end
        if (blue < lo)
        begin
            lo = blue;
        end
        unique case (method_reg)
            METHOD_LIGHTNESS:
            begin
                sum_next = SUM_W'(hi) + SUM_W'(lo);
            end
            METHOD_LUMINOSITY:
            begin
                sum_next = SUM_W'(red) * SUM_W'(W_RED) + SUM_W'(green) * SUM_W'(W_GREEN)
                         + SUM_W'(blue) * SUM_W'(W_BLUE);
            end
            METHOD_AVERAGE, METHOD_AVERAGE_ALT:
            begin
                sum_next = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
            end
            default:
            begin
                sum_next = '0;
            end
        endcase
    end

    assign avg_prod  = AVG_PROD_W'(f1_sum_reg) * AVG_PROD_W'(AVG_RECIP);
    assign luma_prod = LUMA_PROD_W'(f1_sum_reg) * LUMA_PROD_W'(LUMA_RECIP);

    always_comb
    begin
        unique case (f1_method_reg)
            METHOD_LIGHTNESS:
            begin
                grey_next = PIX_W'(f1_sum_reg >> 1);
            end
            METHOD_LUMINOSITY:
            begin
                grey_next = PIX_W'(luma_prod >> LUMA_SHIFT);
            end
            METHOD_AVERAGE, METHOD_AVERAGE_ALT:
            begin
                grey_next = PIX_W'(avg_prod >> AVG_SHIFT);
            end
            default:
            begin
                grey_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg   <= METHOD_AVERAGE;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                method_reg <= method_t'(cfg_data);
            end
            if (f1_adv)
            begin
                f1_valid_reg <= s_tvalid;
            end
            if (f2_adv)
            begin
                f2_valid_reg <= f1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            f1_cmd_reg    <= cmd_t'(s_tuser);
            f1_method_reg <= method_reg;
            f1_sum_reg    <= sum_next;
            f1_idx_reg    <= s_tdata[31:24];
        end
        if (f1_valid_reg && f2_adv)
        begin
            f2_entry_reg.cmd       <= f1_cmd_reg;
            f2_entry_reg.grey      <= grey_next;
            f2_entry_reg.bin_index <= f1_idx_reg;
        end
    end

endmodule

FILE: src/gwh_queue.sv
// short queue between front end and histogram back end
module gwh_queue
    import gwh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  gwh_entry_t push_entry,
    output logic       pop_valid,
    input  logic       pop,
    output gwh_entry_t pop_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    gwh_entry_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != (PTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: src/gwh_back.sv
// back end: histogram update, bin read, clear and result register
module gwh_back
    import gwh_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_pop,
    input  gwh_entry_t  q_entry,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // grey, bin_count
);

    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    logic [COUNT_WIDTH-1:0]  fine_mem [FINE_BINS];
    logic [COUNT_WIDTH-1:0]  rdata_reg;
    logic [FINE_BINS-1:0]    fine_vld_reg, fine_vld_next;
    logic [COUNT_WIDTH-1:0]  coarse_reg [COARSE_BINS];
    logic [COUNT_WIDTH-1:0]  coarse_next [COARSE_BINS];

    logic                    b2_valid_reg;
    gwh_entry_t              b2_entry_reg;

    logic                    fwd_valid_reg, fwd_valid_next;
    logic [PIX_W-1:0]        fwd_addr_reg;
    logic [COUNT_WIDTH-1:0]  fwd_data_reg;

    logic                    out_valid_reg;
    logic [31:0]             out_data_reg;

    logic                    b2_fire;
    logic [PIX_W-1:0]        rd_addr;
    logic [PIX_W-1:0]        b2_addr;
    logic [COUNT_WIDTH-1:0]  fine_cur, fine_inc;
    logic [COARSE_IDX_W-1:0] coarse_addr;
    logic                    coarse_ok;
    logic [COUNT_WIDTH-1:0]  coarse_cur, coarse_inc;
    logic                    is_convert, is_clear;
    logic [PIX_W-1:0]        grey_out;
    logic [COUNT_WIDTH-1:0]  count_out;

    assign b2_fire = b2_valid_reg && (!out_valid_reg || m_tready);
    assign q_pop   = q_valid && (!b2_valid_reg || b2_fire);
    assign rd_addr = (q_entry.cmd == CMD_CONVERT) ? q_entry.grey : q_entry.bin_index;

    assign is_convert = b2_entry_reg.cmd == CMD_CONVERT;
    assign is_clear   = b2_entry_reg.cmd == CMD_CLEAR;
    assign b2_addr    = is_convert ? b2_entry_reg.grey : b2_entry_reg.bin_index;

    // write of the previous result forwarded over the stale read
    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == b2_addr)
        begin
            fine_cur = fwd_data_reg;
        end
        else if (fine_vld_reg[b2_addr])
        begin
            fine_cur = rdata_reg;
        end
        else
        begin
            fine_cur = '0;
        end
    end

    assign fine_inc = (fine_cur == CountMax) ? fine_cur : fine_cur + COUNT_WIDTH'(1);

    assign coarse_addr = is_convert ? coarse_bin(b2_entry_reg.grey)
                                    : b2_entry_reg.bin_index[COARSE_IDX_W-1:0];
    assign coarse_ok   = is_convert
                      || b2_entry_reg.bin_index < PIX_W'(COARSE_BINS);
    assign coarse_cur  = (coarse_ok && coarse_addr < COARSE_IDX_W'(COARSE_BINS))
                       ? coarse_reg[coarse_addr] : '0;
    assign coarse_inc  = (coarse_cur == CountMax) ? coarse_cur
                                                  : coarse_cur + COUNT_WIDTH'(1);

    always_comb
    begin
        fine_vld_next  = fine_vld_reg;
        fwd_valid_next = fwd_valid_reg;
        coarse_next    = coarse_reg;
        if (b2_fire && is_clear)
        begin
            fine_vld_next  = '0;
            fwd_valid_next = 1'b0;
            for (int i = 0; i < COARSE_BINS; i++)
            begin
                coarse_next[i] = '0;
            end
        end
        else if (b2_fire && is_convert)
        begin
            fine_vld_next[b2_addr]  = 1'b1;
            fwd_valid_next          = 1'b1;
            coarse_next[coarse_addr] = coarse_inc;
        end
    end

    always_comb
    begin
        grey_out  = '0;
        count_out = '0;
        unique case (b2_entry_reg.cmd)
            CMD_CONVERT:
            begin
                grey_out = b2_entry_reg.grey;
            end
            CMD_READ_FINE:
            begin
                count_out = fine_cur;
            end
            CMD_READ_COARSE:
            begin
                count_out = coarse_cur;
            end
            CMD_CLEAR:
            begin
                count_out = '0;
            end
            default:
            begin
                count_out = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fine_vld_reg  <= '0;
            fwd_valid_reg <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < COARSE_BINS; i++)
            begin
                coarse_reg[i] <= '0;
            end
        end
        else
        begin
            fine_vld_reg  <= fine_vld_next;
            fwd_valid_reg <= fwd_valid_next;
            coarse_reg    <= coarse_next;
            if (!b2_valid_reg || b2_fire)
            begin
                b2_valid_reg <= q_valid;
            end
            if (b2_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b2_entry_reg <= q_entry;
            rdata_reg    <= fine_mem[rd_addr];
        end
        if (b2_fire && is_convert)
        begin
            fine_mem[b2_addr] <= fine_inc;
            fwd_addr_reg      <= b2_addr;
            fwd_data_reg      <= fine_inc;
        end
        if (b2_fire)
        begin
            out_data_reg <= {OUT_COUNT_W'(count_out), grey_out};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: src/greyscale_with_histogram.sv
// top level of the greyscale converter with fine and coarse histograms
//
//   channel  dir  handshake            payload
//   s        in   s_tvalid/s_tready    tdata red,green,blue,bin_index; tuser command
//   m        out  m_tvalid/m_tready    tdata grey,bin_count
//   cfg      in   cfg_valid/cfg_ready  cfg_data grey_method
//
// one item per clock sustained while the output is not stalled; a result is
// registered through two grey stages, the queue, the histogram memory read
// ahead of the update stage and the result register.
// reset and clear empty both histograms at once, fine bins via per-bin valid bits.
// a stalled output fills the result register and the update stage, then the
// four-entry queue, then the two front stages before s_tready drops.
module greyscale_with_histogram
    import gwh_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red, green, blue, bin_index
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // grey, bin_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data   // grey_method
);

    logic       push_valid;
    logic       push_ready;
    gwh_entry_t push_entry;
    logic       q_valid;
    logic       q_pop;
    gwh_entry_t q_entry;

    gwh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    gwh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (q_entry)
    );

    gwh_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_entry  (q_entry),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: src/gwh_checker.sv
// port checker for the greyscale converter, bound to the top level
module gwh_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // stalled result keeps its valid
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped without a transfer");

    // stalled result keeps its data
    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // a conversion never carries a bin count
    a_grey_or_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7:0] != 8'd0 |-> m_tdata[31:8] == 24'd0)
        else $error("grey and bin count both nonzero");

    // nothing is offered while reset is held
    a_quiet_in_reset: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result offered during reset");

endmodule

bind greyscale_with_histogram gwh_port_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: test/gwh_checker.sv
// result checker for the greyscale converter: tracks grey method and histograms, compares results
module gwh_checker
    import gwh_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // red, green, blue, bin_index
    input  logic [1:0]  s_tuser,   // command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // grey, bin_count
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_data,  // grey_method
    output int          pending,
    output int          failures,
    output int          results
);

    localparam int LUMA_DIV  = 100;
    localparam int AVG_DIV   = 3;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        cmd_t                   cmd;
        logic [PIX_W-1:0]       grey;
        logic [OUT_COUNT_W-1:0] bin_count;
    } result_t;

    logic [COUNT_WIDTH-1:0] fine_counts [FINE_BINS];
    logic [COUNT_WIDTH-1:0] coarse_counts [COARSE_BINS];
    method_t                method_sel;
    result_t                due_results [$];
    result_t                want;
    result_t                seen;

    initial
    begin
        pending  = 0;
        failures = 0;
        results  = 0;
    end

    function automatic logic [PIX_W-1:0] grey_of_pixel(input method_t m,
                                                       input logic [PIX_W-1:0] r,
                                                       input logic [PIX_W-1:0] g,
                                                       input logic [PIX_W-1:0] b);
        int hi;
        int lo;
        case (m)
            METHOD_LIGHTNESS:
            begin
                hi = int'(r);
                lo = int'(r);
                if (int'(g) > hi) hi = int'(g);
                if (int'(b) > hi) hi = int'(b);
                if (int'(g) < lo) lo = int'(g);
                if (int'(b) < lo) lo = int'(b);
                return PIX_W'((hi + lo) / 2);
            end
            METHOD_LUMINOSITY:
                return PIX_W'((W_RED * int'(r) + W_GREEN * int'(g) + W_BLUE * int'(b))
                              / LUMA_DIV);
            default:
                return PIX_W'((int'(r) + int'(g) + int'(b)) / AVG_DIV);
        endcase
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] bumped(input logic [COUNT_WIDTH-1:0] cnt);
        return (&cnt) ? cnt : cnt + 1'b1;
    endfunction

    function automatic void clear_counts();
        for (int i = 0; i < FINE_BINS; i++)
            fine_counts[i] = '0;
        for (int i = 0; i < COARSE_BINS; i++)
            coarse_counts[i] = '0;
    endfunction

    function automatic result_t predict_result(input cmd_t cmd, input logic [31:0] data);
        logic [PIX_W-1:0] grey_val;
        logic [PIX_W-1:0] idx;
        int               coarse;
        result_t          res;
        res.cmd       = cmd;
        res.grey      = '0;
        res.bin_count = '0;
        idx           = data[31:24];
        case (cmd)
            CMD_CONVERT:
            begin
                grey_val = grey_of_pixel(method_sel, data[7:0], data[15:8], data[23:16]);
                coarse   = int'(grey_val) * COARSE_BINS / FINE_BINS;
                fine_counts[grey_val] = bumped(fine_counts[grey_val]);
                if (coarse < COARSE_BINS)
                    coarse_counts[coarse] = bumped(coarse_counts[coarse]);
                res.grey = grey_val;
            end
            CMD_READ_FINE:
                res.bin_count = OUT_COUNT_W'(fine_counts[idx]);
            CMD_READ_COARSE:
            begin
                if (int'(idx) < COARSE_BINS)
                    res.bin_count = OUT_COUNT_W'(coarse_counts[idx]);
            end
            default:
                clear_counts();
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_counts();
            method_sel = METHOD_AVERAGE;
            due_results.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results++;
                seen.grey      = m_tdata[7:0];
                seen.bin_count = m_tdata[31:8];
                if (due_results.size() == 0)
                begin
                    failures++;
                    if (failures <= MAX_SHOWN)
                        $display("unexpected result transfer: grey %0d count %0d",
                                 seen.grey, seen.bin_count);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (seen.grey !== want.grey || seen.bin_count !== want.bin_count)
                    begin
                        failures++;
                        if (failures <= MAX_SHOWN)
                            $display("%s: expected grey %0d count %0d, got grey %0d count %0d",
                                     want.cmd.name(), want.grey, want.bin_count,
                                     seen.grey, seen.bin_count);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                method_sel = method_t'(cfg_data);
            if (s_tvalid && s_tready)
                due_results.push_back(predict_result(cmd_t'(s_tuser), s_tdata));
            pending = due_results.size();
        end
    end

endmodule

FILE: test/testbench.sv
// top of the greyscale converter test: stimulus, flow control and the final verdict
module testbench;
    import gwh_pkg::*;

    localparam int RESULT_LATENCY   = 4;
    localparam int ITEMS_PER_PHASE  = 86;
    localparam int PHASES           = 5;
    localparam int HOLD_CYCLES      = 64;
    localparam int CYCLE_LIMIT      = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // red, green, blue, bin_index
    logic [1:0]  s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // grey, bin_count
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;  // grey_method

    int pending;
    int failures;
    int results;
    int cycles = 0;
    int n_convert = 0;
    int n_read_fine = 0;
    int n_read_coarse = 0;
    int n_clear = 0;
    bit steady = 1'b0;
    bit hold_req = 1'b0;

    method_t phase_methods [PHASES] = '{METHOD_LIGHTNESS, METHOD_LUMINOSITY,
                                        METHOD_AVERAGE_ALT, METHOD_AVERAGE,
                                        METHOD_LUMINOSITY};

    greyscale_with_histogram #(.COUNT_WIDTH(COUNT_WIDTH_DEF)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    gwh_checker #(.COUNT_WIDTH(COUNT_WIDTH_DEF)) result_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .failures  (failures),
        .results   (results)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[greyscale_with_histogram] ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end
            else
                m_tready = 1'b1;
        end
    end

    task automatic feed_item(input cmd_t cmd, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] idx);
        s_tvalid = 1'b1;
        s_tdata  = {idx, b, g, r};
        s_tuser  = cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        case (cmd)
            CMD_CONVERT:     n_convert++;
            CMD_READ_FINE:   n_read_fine++;
            CMD_READ_COARSE: n_read_coarse++;
            default:         n_clear++;
        endcase
    endtask

    task automatic pause_feed(input int n);
        s_tvalid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic write_method(input method_t m);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (RESULT_LATENCY + 4) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] any_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly pixels; some pixels and fine reads sit around one grey level so updates and reads collide
    task automatic random_item(input logic [7:0] hot);
        int         pick;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] idx;
        logic [7:0] level;
        pick = $urandom_range(0, 99);
        r    = any_level();
        g    = any_level();
        b    = any_level();
        idx  = 8'($urandom_range(0, 255));
        if (pick < 60)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                level = hot + 8'($urandom_range(0, 3));
                r     = level;
                g     = level;
                b     = level;
            end
            feed_item(CMD_CONVERT, r, g, b, idx);
        end
        else if (pick < 78)
        begin
            if ($urandom_range(0, 1) == 1)
                idx = hot - 8'($urandom_range(0, 3));
            feed_item(CMD_READ_FINE, r, g, b, idx);
        end
        else if (pick < 96)
        begin
            if ($urandom_range(0, 3) != 0)
                idx = 8'($urandom_range(0, 11));
            feed_item(CMD_READ_COARSE, r, g, b, idx);
        end
        else
            feed_item(CMD_CLEAR, r, g, b, idx);
    endtask

    initial
    begin
        logic [7:0] hot;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_CONVERT;
        cfg_valid = 1'b0;
        cfg_data  = METHOD_AVERAGE;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty stores, extreme pixels, edge bins, clear
        feed_item(CMD_READ_FINE,   8'd0,   8'd0,   8'd0,   8'd0);
        feed_item(CMD_READ_COARSE, 8'd0,   8'd0,   8'd0,   8'd0);
        feed_item(CMD_CONVERT,     8'd0,   8'd0,   8'd0,   8'd0);
        feed_item(CMD_CONVERT,     8'd255, 8'd255, 8'd255, 8'd0);
        feed_item(CMD_CONVERT,     8'd255, 8'd0,   8'd0,   8'd0);
        feed_item(CMD_CONVERT,     8'd0,   8'd255, 8'd0,   8'd0);
        feed_item(CMD_CONVERT,     8'd0,   8'd0,   8'd255, 8'd0);
        feed_item(CMD_CONVERT,     8'd255, 8'd255, 8'd255, 8'd0);
        feed_item(CMD_READ_FINE,   8'd0,   8'd0,   8'd0,   8'd0);
        feed_item(CMD_READ_FINE,   8'd0,   8'd0,   8'd0,   8'd255);
        feed_item(CMD_READ_FINE,   8'd0,   8'd0,   8'd0,   8'd85);
        feed_item(CMD_READ_COARSE, 8'd0,   8'd0,   8'd0,   8'd9);
        feed_item(CMD_READ_COARSE, 8'd0,   8'd0,   8'd0,   8'd10);
        feed_item(CMD_READ_COARSE, 8'd0,   8'd0,   8'd0,   8'd255);
        feed_item(CMD_CLEAR,       8'd0,   8'd0,   8'd0,   8'd0);
        feed_item(CMD_READ_FINE,   8'd0,   8'd0,   8'd0,   8'd255);
        feed_item(CMD_READ_COARSE, 8'd0,   8'd0,   8'd0,   8'd3);
        feed_item(CMD_CONVERT,     8'd255, 8'd255, 8'd255, 8'd0);
        feed_item(CMD_READ_FINE,   8'd0,   8'd0,   8'd0,   8'd255);
        feed_item(CMD_READ_COARSE, 8'd0,   8'd0,   8'd0,   8'd9);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_method(phase_methods[phase]);
            hot = 8'($urandom_range(0, 255));
            if (phase == 1)
                hold_req = 1'b1;
            if (phase == PHASES - 1)
                steady = 1'b1;
            repeat (ITEMS_PER_PHASE)
            begin
                if (!steady && !hold_req && $urandom_range(0, 4) == 0)
                    pause_feed($urandom_range(1, 19));
                random_item(hot);
            end
        end
        s_tvalid = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (RESULT_LATENCY + 8) @(negedge clk);

        $display("covered %0d conversions, %0d fine reads, %0d coarse reads, %0d clears",
                 n_convert, n_read_fine, n_read_coarse, n_clear);
        $display("all grey methods set, %0d results checked, output held %0d cycles once",
                 results, HOLD_CYCLES);
        if (failures == 0 && pending == 0)
            $display("[greyscale_with_histogram] OK");
        else
            $display("[greyscale_with_histogram] ERROR");
        $finish;
    end

endmodule
